[design/mph_pkg.sv]
`default_nettype none

package mph_pkg;

  localparam int StoreDepth = 128;
  localparam int ValueWidth = 32;
  localparam int AddrWidth  = $clog2(StoreDepth);
  localparam int CountWidth = AddrWidth;
  localparam int Capacity   = StoreDepth - 1;

  localparam logic OpInsert = 1'b0;
  localparam logic OpRemove = 1'b1;

  typedef enum logic [1:0] {
    StatusDone  = 2'd0,
    StatusEmpty = 2'd1,
    StatusFull  = 2'd2
  } status_e;

endpackage

`default_nettype wire

[design/mph_ram.sv]
`default_nettype none

module mph_ram #(
  parameter int Depth = 128,
  parameter int Width = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_a_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic      [Width-1:0]         rdata_a_o,
  output logic      [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule

`default_nettype wire

[design/max_heap_priority_queue.sv]
`default_nettype none

// Binary max-heap priority queue of signed values, holding up to StoreDepth-1 entries in one
// synchronous RAM (one write port, two registered read ports). An item is taken when start_i
// is high and busy_o is low; operation_i selects insert (value_i) or remove-maximum. Exactly one
// result follows per item, shown for one cycle with done_o high; it cannot be held off, so it
// must be captured in that cycle. Results: status (done, remove from empty, insert into full,
// the last two leaving the heap unchanged), the removed maximum (zero if none), the new
// maximum (zero when empty) and the entry count. Rejected items and a removal that empties
// the heap report in the cycle after acceptance. Otherwise the sift walks one tree level at a
// time, each level a RAM read and then a compare and write-back, and the next item can be
// taken in the cycle in which the result is shown. No clearing pass is needed after reset.

module max_heap_priority_queue
  import mph_pkg::*;
(
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  output logic                              busy_o,
  input  wire logic                         operation_i,
  input  wire logic signed [ValueWidth-1:0] value_i,
  output logic                              done_o,
  output logic             [1:0]            status_o,
  output logic signed      [ValueWidth-1:0] removed_value_o,
  output logic signed      [ValueWidth-1:0] top_value_o,
  output logic             [CountWidth-1:0] entry_count_o
);

  typedef enum logic [2:0] {
    Idle,
    UpRead,
    UpCmp,
    DnLast,
    DnRead,
    DnCmp
  } state_e;

  state_e                         state_q;
  logic [AddrWidth-1:0]           pos_q;
  logic signed [ValueWidth-1:0]   v_q;
  logic [CountWidth-1:0]          count_q;
  logic signed [ValueWidth-1:0]   top_q;
  logic signed [ValueWidth-1:0]   rem_q;
  logic signed [ValueWidth-1:0]   top_out_q;
  status_e                        status_q;
  logic                           done_q;

  logic                           we;
  logic [AddrWidth-1:0]           waddr;
  logic [ValueWidth-1:0]          wdata;
  logic [AddrWidth-1:0]           raddr_a;
  logic [AddrWidth-1:0]           raddr_b;
  logic [ValueWidth-1:0]          rdata_a;
  logic [ValueWidth-1:0]          rdata_b;
  logic                           fin;

  logic [AddrWidth-1:0]           parent_c;
  logic [AddrWidth:0]             left_c;
  logic [AddrWidth:0]             right_c;
  logic                           left_ok;
  logic                           right_ok;
  logic                           pick_right;
  logic signed [ValueWidth-1:0]   big_val;
  logic [AddrWidth-1:0]           big_addr;
  logic signed [ValueWidth-1:0]   top_new;

  mph_ram #(
    .Depth(StoreDepth),
    .Width(ValueWidth)
  ) u_ram (
    .clk_i    (clk_i),
    .we_i     (we),
    .waddr_i  (waddr),
    .wdata_i  (wdata),
    .raddr_a_i(raddr_a),
    .raddr_b_i(raddr_b),
    .rdata_a_o(rdata_a),
    .rdata_b_o(rdata_b)
  );

  assign parent_c   = (pos_q - AddrWidth'(1)) >> 1;
  assign left_c     = {pos_q, 1'b1};
  assign right_c    = left_c + (AddrWidth + 1)'(1);
  assign left_ok    = left_c < {1'b0, count_q};
  assign right_ok   = right_c < {1'b0, count_q};
  assign pick_right = right_ok && ($signed(rdata_b) > $signed(rdata_a));
  assign big_val    = pick_right ? $signed(rdata_b) : $signed(rdata_a);
  assign big_addr   = pick_right ? right_c[AddrWidth-1:0] : left_c[AddrWidth-1:0];

  always_comb begin
    we      = 1'b0;
    waddr   = pos_q;
    wdata   = v_q;
    raddr_a = count_q - CountWidth'(1);
    raddr_b = right_c[AddrWidth-1:0];
    fin     = 1'b0;
    case (state_q)
      UpRead: begin
        if (pos_q == '0) begin
          we  = 1'b1;
          fin = 1'b1;
        end else begin
          raddr_a = parent_c;
        end
      end
      UpCmp: begin
        we = 1'b1;
        if ($signed(rdata_a) < v_q) begin
          wdata = rdata_a;
        end else begin
          fin = 1'b1;
        end
      end
      DnRead: begin
        if (!left_ok) begin
          we  = 1'b1;
          fin = 1'b1;
        end else begin
          raddr_a = left_c[AddrWidth-1:0];
        end
      end
      DnCmp: begin
        we = 1'b1;
        if (big_val > v_q) begin
          wdata = big_val;
        end else begin
          fin = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign top_new = (we && waddr == '0) ? $signed(wdata) : top_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= Idle;
      pos_q     <= '0;
      v_q       <= '0;
      count_q   <= '0;
      top_q     <= '0;
      rem_q     <= '0;
      top_out_q <= '0;
      status_q  <= StatusDone;
      done_q    <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (we && waddr == '0) begin
        top_q <= $signed(wdata);
      end
      case (state_q)
        Idle: begin
          if (start_i) begin
            if (operation_i == OpInsert) begin
              rem_q <= '0;
              if (count_q >= CountWidth'(Capacity)) begin
                done_q    <= 1'b1;
                status_q  <= StatusFull;
                top_out_q <= top_q;
              end else begin
                pos_q   <= count_q;
                v_q     <= value_i;
                count_q <= count_q + CountWidth'(1);
                state_q <= UpRead;
              end
            end else if (count_q == '0) begin
              rem_q     <= '0;
              done_q    <= 1'b1;
              status_q  <= StatusEmpty;
              top_out_q <= '0;
            end else begin
              rem_q   <= top_q;
              count_q <= count_q - CountWidth'(1);
              pos_q   <= '0;
              if (count_q == CountWidth'(1)) begin
                done_q    <= 1'b1;
                status_q  <= StatusDone;
                top_out_q <= '0;
              end else begin
                state_q <= DnLast;
              end
            end
          end
        end
        UpRead, DnRead: begin
          if (fin) begin
            done_q    <= 1'b1;
            status_q  <= StatusDone;
            top_out_q <= top_new;
            state_q   <= Idle;
          end else begin
            state_q <= (state_q == UpRead) ? UpCmp : DnCmp;
          end
        end
        UpCmp: begin
          if (fin) begin
            done_q    <= 1'b1;
            status_q  <= StatusDone;
            top_out_q <= top_new;
            state_q   <= Idle;
          end else begin
            pos_q   <= parent_c;
            state_q <= UpRead;
          end
        end
        DnLast: begin
          v_q     <= $signed(rdata_a);
          state_q <= DnRead;
        end
        DnCmp: begin
          if (fin) begin
            done_q    <= 1'b1;
            status_q  <= StatusDone;
            top_out_q <= top_new;
            state_q   <= Idle;
          end else begin
            pos_q   <= big_addr;
            state_q <= DnRead;
          end
        end
        default: begin
          state_q <= Idle;
        end
      endcase
    end
  end

  assign busy_o          = (state_q != Idle);
  assign done_o          = done_q;
  assign status_o        = status_q;
  assign removed_value_o = rem_q;
  assign top_value_o     = top_out_q;
  assign entry_count_o   = count_q;

`ifndef NO_ASSERTIONS
  a_empty_remove: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && operation_i == OpRemove && entry_count_o == '0)
      |=> (done_o && status_o == StatusEmpty))
    else $error("remove from empty heap not flagged");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result shown while still busy");

  a_no_idle_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o |-> !we)
    else $error("heap written while idle");

  a_empty_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && entry_count_o == '0) |-> top_value_o == '0)
    else $error("nonzero maximum reported for empty heap");
`endif

endmodule

`default_nettype wire

[tb/tb_heap_pkg.sv]
`timescale 1ns / 100ps

package tb_heap_pkg;
  import mph_pkg::*;

  typedef struct {
    status_e                      status;
    logic signed [ValueWidth-1:0] removed;
    logic signed [ValueWidth-1:0] top;
    logic        [CountWidth-1:0] count;
  } heap_result_t;

  class heap_scoreboard;
    logic signed [ValueWidth-1:0] heap_mem[StoreDepth];
    int unsigned                  fill;
    heap_result_t                 expected_q[$];
    int unsigned                  errors;

    function new();
      fill   = 0;
      errors = 0;
    endfunction

    function int unsigned count();
      return fill;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void swap_slots(int unsigned a, int unsigned b);
      logic signed [ValueWidth-1:0] t;
      t           = heap_mem[a];
      heap_mem[a] = heap_mem[b];
      heap_mem[b] = t;
    endfunction

    // predict the result of one accepted item and update the heap copy
    function void note_item(logic op, logic signed [ValueWidth-1:0] value);
      heap_result_t res;
      int unsigned  pos;
      int unsigned  up;
      int unsigned  lc;
      int unsigned  big;
      res.status  = StatusDone;
      res.removed = '0;
      res.top     = '0;
      if (op == OpInsert) begin
        if (fill >= Capacity) begin
          res.status = StatusFull;
        end else begin
          heap_mem[fill] = value;
          pos  = fill;
          fill = fill + 1;
          while (pos > 0) begin
            up = (pos - 1) / 2;
            if (heap_mem[up] < heap_mem[pos]) begin
              swap_slots(up, pos);
              pos = up;
            end else begin
              break;
            end
          end
        end
      end else begin
        if (fill == 0) begin
          res.status = StatusEmpty;
        end else begin
          res.removed = heap_mem[0];
          fill        = fill - 1;
          heap_mem[0] = heap_mem[fill];
          pos         = 0;
          forever begin
            lc = 2 * pos + 1;
            if (lc >= fill) break;
            big = lc;
            if (lc + 1 < fill && heap_mem[lc + 1] > heap_mem[lc]) big = lc + 1;
            if (heap_mem[big] > heap_mem[pos]) begin
              swap_slots(big, pos);
              pos = big;
            end else begin
              break;
            end
          end
        end
      end
      if (fill > 0) res.top = heap_mem[0];
      res.count = fill[CountWidth-1:0];
      expected_q.push_back(res);
    endfunction

    function void check_result(logic [1:0] status, logic signed [ValueWidth-1:0] removed,
                               logic signed [ValueWidth-1:0] top,
                               logic [CountWidth-1:0] cnt);
      heap_result_t exp_res;
      if (expected_q.size() == 0) begin
        if (errors < 10)
          $display("unexpected result: status %0d removed %0d top %0d count %0d",
                   status, removed, top, cnt);
        errors++;
        return;
      end
      exp_res = expected_q.pop_front();
      if (status !== exp_res.status || removed !== exp_res.removed ||
          top !== exp_res.top || cnt !== exp_res.count) begin
        if (errors < 10)
          $display("mismatch: exp status %0d removed %0d top %0d count %0d, got %0d %0d %0d %0d",
                   exp_res.status, exp_res.removed, exp_res.top, exp_res.count,
                   status, removed, top, cnt);
        errors++;
      end
    endfunction
  endclass

endpackage

[tb/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
  import mph_pkg::*;
  import tb_heap_pkg::*;

  typedef enum {SegMix, SegTies, SegFill, SegDrain} seg_e;

  logic                         clk_i       = 1'b0;
  logic                         rst_ni      = 1'b0;
  logic                         start_i     = 1'b0;
  logic                         operation_i = OpInsert;
  logic signed [ValueWidth-1:0] value_i     = '0;
  logic                         busy_o;
  logic                         done_o;
  logic        [1:0]            status_o;
  logic signed [ValueWidth-1:0] removed_value_o;
  logic signed [ValueWidth-1:0] top_value_o;
  logic        [CountWidth-1:0] entry_count_o;

  heap_scoreboard sb;
  int unsigned    items_sent = 0;
  int unsigned    idle_pct   = 0;

  max_heap_priority_queue u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .operation_i    (operation_i),
    .value_i        (value_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .removed_value_o(removed_value_o),
    .top_value_o    (top_value_o),
    .entry_count_o  (entry_count_o)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) sb.check_result(status_o, removed_value_o, top_value_o, entry_count_o);
      if (start_i && !busy_o) sb.note_item(operation_i, value_i);
    end
  end

  task automatic send_item(input logic op, input logic signed [ValueWidth-1:0] val);
    if ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    start_i     <= 1'b1;
    operation_i <= op;
    value_i     <= val;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic wait_drained();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  function automatic logic signed [ValueWidth-1:0] pick_value();
    case ($urandom_range(15))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic pick_op();
    return ($urandom_range(99) < 55) ? OpInsert : OpRemove;
  endfunction

  task automatic run_phase(input int unsigned target, input int unsigned pct);
    int unsigned r;
    seg_e        seg;
    int unsigned seg_len;
    int unsigned extra;
    idle_pct = pct;
    target   = items_sent + target;
    while (items_sent < target) begin
      r       = $urandom_range(9);
      seg     = (r < 5 || r == 9) ? SegMix : (r < 7) ? SegTies : (r == 7) ? SegFill : SegDrain;
      seg_len = $urandom_range(40, 5);
      extra   = $urandom_range(4, 1);
      case (seg)
        SegMix: begin
          repeat (seg_len) send_item(pick_op(), pick_value());
        end
        SegTies: begin
          repeat (seg_len) send_item(pick_op(), $urandom_range(6) - 3);
        end
        SegFill: begin
          while (sb.count() < Capacity) send_item(OpInsert, pick_value());
          repeat (extra) send_item(OpInsert, pick_value());
        end
        SegDrain: begin
          while (sb.count() > 0) send_item(OpRemove, pick_value());
          repeat (extra) send_item(OpRemove, pick_value());
        end
      endcase
      if ($urandom_range(49) == 0) wait_drained();
    end
    wait_drained();
  endtask

  initial begin
    sb = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty remove, extremes, ties, removal order
    idle_pct = 0;
    send_item(OpRemove, 32'h1234_5678);
    send_item(OpInsert, 32'h8000_0000);
    send_item(OpRemove, '0);
    send_item(OpInsert, 32'h7FFF_FFFF);
    send_item(OpInsert, 32'h8000_0000);
    send_item(OpInsert, '0);
    send_item(OpInsert, '1);
    send_item(OpInsert, 5);
    send_item(OpInsert, 5);
    send_item(OpInsert, 5);
    send_item(OpInsert, 32'h7FFF_FFFF);
    send_item(OpInsert, -7);
    repeat (10) send_item(OpRemove, 32'hFFFF_FFFF);
    send_item(OpRemove, '0);
    wait_drained();

    run_phase(600, 18);
    run_phase(600, 58);
    run_phase(630, 0);

    repeat (20) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
